/* rtl/pwm_period_duty_to_registers_defines.svh */
// Assertion macros for the checker of the PWM register calculator.
`ifndef PWM_PERIOD_DUTY_TO_REGISTERS_DEFINES_SVH
`define PWM_PERIOD_DUTY_TO_REGISTERS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWM_PD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwm_pd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWM_PD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwm_pd: next-cycle check failed");

`endif

/* rtl/pwm_pd_pkg.sv */
`default_nettype none

package pwm_pd_pkg;

    localparam int CLK_W      = 42;
    localparam int PERIOD_W   = 32;
    localparam int PROD_W     = CLK_W + PERIOD_W;
    localparam int REM_W      = 48;
    localparam int ALU_W      = REM_W + 1;
    localparam int QUOT_W     = PERIOD_W + 1;
    localparam int FREQ_W     = 18;
    localparam int DUTY_W     = 12;
    localparam int IMG_W      = 12;
    localparam int CNT_W      = 6;

    localparam int MUL_STEPS  = PERIOD_W / 2;
    localparam int DIV1_STEPS = QUOT_W;
    localparam int DIV2_STEPS = DUTY_W;

    localparam int CHANNELS   = 4;
    localparam int DUTY_STEPS = 4096;

    localparam logic [CLK_W-1:0]  CLK_RESET = 42'd200000000;
    localparam logic [CLK_W-1:0]  FREQ_DIV  = 42'd4096000000000;
    localparam logic [29:0]       NS_PER_S  = 30'd1000000000;
    localparam logic [FREQ_W-1:0] FREQ_MAX  = 18'h3FFFF;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(DUTY_STEPS - 1);

    typedef struct packed {
        logic [1:0]  channel;
        logic        enable;
        logic        inverted;
        logic [31:0] period_len;
        logic [31:0] duty_ns;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [FREQ_W-1:0] freq_word;
        logic              freq_written;
        logic [17:0]       duty_word;
        logic              duty_written;
        logic [IMG_W-1:0]  mode0_word;
        logic              mode0_written;
        logic [IMG_W-1:0]  mode1_word;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_LOAD1,
        ST_DIV1,
        ST_SCALE,
        ST_MUL2,
        ST_CMP,
        ST_DIV2,
        ST_SAT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_MUL_LOAD,
        DP_MUL_STEP,
        DP_DIV1_LOAD,
        DP_DIV_STEP,
        DP_CMP
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t           cmd;
        logic [31:0]       mul_op;
        logic [FREQ_W-1:0] freq;
    } dp_ctrl_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              over;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/pwm_pd_alu.sv */
`default_nettype none

module pwm_pd_alu (
    input  logic [pwm_pd_pkg::ALU_W-1:0] op_a,
    input  logic [pwm_pd_pkg::ALU_W-1:0] op_b,
    input  logic                         sub,
    output logic [pwm_pd_pkg::ALU_W-1:0] sum,
    output logic                         carry
);
    import pwm_pd_pkg::*;

    logic [ALU_W:0] full;

    // On subtraction the carry out is set when op_a is not below op_b.
    assign full  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{ALU_W{1'b0}}, sub};
    assign sum   = full[ALU_W-1:0];
    assign carry = full[ALU_W];

endmodule

`default_nettype wire

/* rtl/pwm_pd_datapath.sv */
`default_nettype none

module pwm_pd_datapath (
    input  logic                         clk,
    input  logic [pwm_pd_pkg::CLK_W-1:0] clock_rate,
    input  pwm_pd_pkg::dp_ctrl_t         ctrl,
    output pwm_pd_pkg::dp_stat_t         stat
);
    import pwm_pd_pkg::*;

    logic [PROD_W-1:0] p_reg, p_next;
    logic [43:0]       m3_reg, m3_next;
    logic [REM_W-1:0]  r_reg, r_next;
    logic [REM_W-1:0]  d_reg, d_next;
    logic [QUOT_W-1:0] n_reg, n_next;

    logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;
    logic [ALU_W-1:0]  div_t;
    logic [REM_W-1:0]  scaled;

    pwm_pd_alu u_alu (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Operand selection for the one shared adder.
    always_comb
    begin
        div_t   = {r_reg, n_reg[QUOT_W-1]};
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.cmd)
            DP_MUL_LOAD:
            begin
                // Three times the clock rate, for radix-4 multiplier digits.
                alu_a = {7'b0, clock_rate};
                alu_b = {6'b0, clock_rate, 1'b0};
            end
            DP_MUL_STEP:
            begin
                alu_a = {7'b0, p_reg[73:32]};
                case (p_reg[1:0])
                    2'd1:    alu_b = {7'b0, clock_rate};
                    2'd2:    alu_b = {6'b0, clock_rate, 1'b0};
                    2'd3:    alu_b = {5'b0, m3_reg};
                    default: alu_b = '0;
                endcase
            end
            DP_DIV_STEP:
            begin
                alu_a   = div_t;
                alu_b   = {1'b0, d_reg};
                alu_sub = 1'b1;
            end
            DP_CMP:
            begin
                alu_a   = {1'b0, p_reg[59:12]};
                alu_b   = {1'b0, d_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign scaled = {30'b0, ctrl.freq} * {18'b0, NS_PER_S};

    always_comb
    begin
        p_next  = p_reg;
        m3_next = m3_reg;
        r_next  = r_reg;
        d_next  = d_reg;
        n_next  = n_reg;
        case (ctrl.cmd)
            DP_MUL_LOAD:
            begin
                p_next  = {42'b0, ctrl.mul_op};
                m3_next = alu_sum[43:0];
                d_next  = scaled;
            end
            DP_MUL_STEP:
            begin
                p_next = {alu_sum[43:0], p_reg[31:2]};
            end
            DP_DIV1_LOAD:
            begin
                // The quotient fits 33 bits, so the top of the product starts as remainder.
                r_next = {7'b0, p_reg[73:33]};
                n_next = p_reg[32:0];
                d_next = {6'b0, FREQ_DIV};
            end
            DP_DIV_STEP:
            begin
                r_next = alu_carry ? alu_sum[REM_W-1:0] : div_t[REM_W-1:0];
                n_next = {n_reg[QUOT_W-2:0], alu_carry};
            end
            DP_CMP:
            begin
                // Only twelve quotient bits remain once the count is known to fit.
                r_next = p_reg[59:12];
                n_next = {p_reg[11:0], 21'b0};
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        m3_reg <= m3_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        n_reg  <= n_next;
    end

    assign stat.quot = n_reg;
    assign stat.over = (|p_reg[73:60]) | alu_carry;

endmodule

`default_nettype wire

/* rtl/pwm_pd_ctrl.sv */
`default_nettype none

module pwm_pd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pwm_pd_pkg::CLK_W-1:0] clock_rate,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  pwm_pd_pkg::req_t             req_word,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output pwm_pd_pkg::rsp_t             rsp_word,
    output pwm_pd_pkg::dp_ctrl_t         dp_ctrl,
    input  pwm_pd_pkg::dp_stat_t         dp_stat
);
    import pwm_pd_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [IMG_W-1:0]    mode0_reg, mode0_next;
    logic [IMG_W-1:0]    mode1_reg, mode1_next;

    logic [1:0]          ch_reg, ch_next;
    logic                inv_reg, inv_next;
    logic [31:0]         duty_reg, duty_next;
    logic                eq_reg, eq_next;
    logic                ch_ok_reg, ch_ok_next;
    logic                status_reg, status_next;
    logic                run_reg, run_next;
    logic                m0w_reg, m0w_next;
    logic                bypass_reg, bypass_next;
    logic [DUTY_W-1:0]   cnt_reg, cnt_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;

    logic                ch_ok_in, too_fast, slot_free, last_step;
    logic [FREQ_W-1:0]   freq_clamp;
    logic [DUTY_W-1:0]   quot_cnt;
    logic [3:0]          en_idx, byp_idx;
    logic [IMG_W-1:0]    m0_new, m1_new;

    assign ch_ok_in   = {1'b0, req_word.channel} < 3'(CHANNELS);
    assign too_fast   = clock_rate > FREQ_DIV;
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign last_step  = (step_reg == '0);
    assign freq_clamp = (dp_stat.quot > {15'b0, FREQ_MAX}) ? FREQ_MAX
                                                           : dp_stat.quot[FREQ_W-1:0];
    assign quot_cnt   = dp_stat.quot[DUTY_W-1:0];
    assign en_idx     = {2'b0, ch_reg};
    assign byp_idx    = 4'd8 + {2'b0, ch_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (!ch_ok_in || !req_word.enable || too_fast)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_MUL1;
                end
            end
            ST_MUL1:   if (last_step) state_next = ST_LOAD1;
            ST_LOAD1:  state_next = ST_DIV1;
            ST_DIV1:   if (last_step) state_next = ST_SCALE;
            ST_SCALE:
            begin
                if ((dp_stat.quot == '0) || eq_reg)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL2;
            end
            ST_MUL2:   if (last_step) state_next = ST_CMP;
            ST_CMP:    state_next = dp_stat.over ? ST_FINISH : ST_DIV2;
            ST_DIV2:   if (last_step) state_next = ST_SAT;
            ST_SAT:    state_next = ST_FINISH;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs to the datapath and the request side.
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        dp_ctrl.cmd    = DP_HOLD;
        dp_ctrl.mul_op = duty_reg;
        dp_ctrl.freq   = freq_clamp;
        case (state_reg)
            ST_IDLE:
            begin
                dp_ctrl.cmd    = DP_MUL_LOAD;
                dp_ctrl.mul_op = req_word.period_len;
            end
            ST_MUL1:  dp_ctrl.cmd = DP_MUL_STEP;
            ST_LOAD1: dp_ctrl.cmd = DP_DIV1_LOAD;
            ST_DIV1:  dp_ctrl.cmd = DP_DIV_STEP;
            ST_SCALE: dp_ctrl.cmd = DP_MUL_LOAD;
            ST_MUL2:  dp_ctrl.cmd = DP_MUL_STEP;
            ST_CMP:   dp_ctrl.cmd = DP_CMP;
            ST_DIV2:  dp_ctrl.cmd = DP_DIV_STEP;
            default:  dp_ctrl.cmd = DP_HOLD;
        endcase
    end

    // Step counter.
    always_comb
    begin
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:  step_next = CNT_W'(MUL_STEPS - 1);
            ST_SCALE: step_next = CNT_W'(MUL_STEPS - 1);
            ST_LOAD1: step_next = CNT_W'(DIV1_STEPS - 1);
            ST_CMP:   step_next = CNT_W'(DIV2_STEPS - 1);
            ST_MUL1, ST_MUL2, ST_DIV1, ST_DIV2:
                step_next = step_reg - 1'b1;
            default:  step_next = step_reg;
        endcase
    end

    // Register images as they stand after the word in hand.
    always_comb
    begin
        m0_new = mode0_reg;
        m1_new = mode1_reg;
        if (ch_ok_reg)
            m1_new[byp_idx] = inv_reg;
        if (m0w_reg)
        begin
            m0_new[en_idx] = run_reg;
            if (run_reg)
                m0_new[byp_idx] = bypass_reg;
        end
    end

    // Word fields and outcome.
    always_comb
    begin
        ch_next        = ch_reg;
        inv_next       = inv_reg;
        duty_next      = duty_reg;
        eq_next        = eq_reg;
        ch_ok_next     = ch_ok_reg;
        status_next    = status_reg;
        run_next       = run_reg;
        m0w_next       = m0w_reg;
        bypass_next    = bypass_reg;
        cnt_next       = cnt_reg;
        freq_next      = freq_reg;
        mode0_next     = mode0_reg;
        mode1_next     = mode1_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ch_next     = req_word.channel;
                    inv_next    = req_word.inverted;
                    duty_next   = req_word.duty_ns;
                    eq_next     = (req_word.period_len == req_word.duty_ns);
                    ch_ok_next  = ch_ok_in;
                    status_next = !ch_ok_in || (req_word.enable && too_fast);
                    run_next    = 1'b0;
                    m0w_next    = ch_ok_in && !req_word.enable;
                    bypass_next = 1'b0;
                end
            end
            ST_SCALE:
            begin
                freq_next = freq_clamp;
                if (dp_stat.quot == '0)
                    status_next = 1'b1;
                else if (eq_reg)
                begin
                    run_next    = 1'b1;
                    m0w_next    = 1'b1;
                    bypass_next = 1'b1;
                    cnt_next    = DUTY_MAX;
                end
            end
            ST_CMP:
            begin
                if (dp_stat.over)
                begin
                    run_next    = 1'b1;
                    m0w_next    = 1'b1;
                    bypass_next = 1'b0;
                    cnt_next    = DUTY_MAX;
                end
            end
            ST_SAT:
            begin
                run_next    = 1'b1;
                m0w_next    = 1'b1;
                bypass_next = 1'b0;
                cnt_next    = (quot_cnt > DUTY_MAX) ? DUTY_MAX : quot_cnt;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    mode0_next             = m0_new;
                    mode1_next             = m1_new;
                    rsp_valid_next         = 1'b1;
                    rsp_next.status        = status_reg;
                    rsp_next.freq_word     = run_reg ? freq_reg : '0;
                    rsp_next.freq_written  = run_reg;
                    rsp_next.duty_word     = run_reg ? {ch_reg, 4'b0, cnt_reg} : '0;
                    rsp_next.duty_written  = run_reg;
                    rsp_next.mode0_word    = m0_new;
                    rsp_next.mode0_written = m0w_reg;
                    rsp_next.mode1_word    = m1_new;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            mode0_reg     <= '0;
            mode1_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
            mode0_reg     <= mode0_next;
            mode1_reg     <= mode1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        ch_reg     <= ch_next;
        inv_reg    <= inv_next;
        duty_reg   <= duty_next;
        eq_reg     <= eq_next;
        ch_ok_reg  <= ch_ok_next;
        status_reg <= status_next;
        run_reg    <= run_next;
        m0w_reg    <= m0w_next;
        bypass_reg <= bypass_next;
        cnt_reg    <= cnt_next;
        freq_reg   <= freq_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

`default_nettype wire

/* rtl/pwm_period_duty_to_registers.sv */
// A request word is taken only while the sequencer is idle, so one word is in hand at a
// time. The shared adder runs two radix-4 multiplications (16 steps each) and two
// restoring divisions (33 and 12 steps). Reset clears the mode images, the sequencer and
// the result slot, and sets the clock rate register to 200 MHz; no clearing pass is needed.
`default_nettype none

module pwm_period_duty_to_registers (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [pwm_pd_pkg::CLK_W-1:0] cfg_wdata,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  pwm_pd_pkg::req_t             req_word,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output pwm_pd_pkg::rsp_t             rsp_word
);
    import pwm_pd_pkg::*;

    logic [CLK_W-1:0] clock_rate_reg, clock_rate_next;
    dp_ctrl_t         dp_ctrl;
    dp_stat_t         dp_stat;

    assign clock_rate_next = cfg_write ? cfg_wdata : clock_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_rate_reg <= CLK_RESET;
        else
            clock_rate_reg <= clock_rate_next;
    end

    pwm_pd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .clock_rate (clock_rate_reg),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .dp_ctrl    (dp_ctrl),
        .dp_stat    (dp_stat)
    );

    pwm_pd_datapath u_datapath (
        .clk        (clk),
        .clock_rate (clock_rate_reg),
        .ctrl       (dp_ctrl),
        .stat       (dp_stat)
    );

endmodule

`default_nettype wire

/* rtl/pwm_pd_checker.sv */
`default_nettype none
`include "pwm_period_duty_to_registers_defines.svh"

module pwm_pd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input pwm_pd_pkg::rsp_t rsp_word
);

    // A result word waiting on the far side holds still.
    `PWM_PD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

    // Once a request word is taken the block is busy with it.
    `PWM_PD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

    // Frequency and duty words that are not written read as zero.
    `PWM_PD_ASSERT_SAME(a_unwritten_zero, rsp_valid && !rsp_word.freq_written,
        (rsp_word.freq_word == 0) && (rsp_word.duty_word == 0) && !rsp_word.duty_written)

    // A rejected request writes neither frequency nor mode0.
    `PWM_PD_ASSERT_SAME(a_reject_no_write, rsp_valid && rsp_word.status,
        !rsp_word.freq_written && !rsp_word.mode0_written)

    // A written divider is never zero and always comes with duty and mode0 writes.
    `PWM_PD_ASSERT_SAME(a_run_writes, rsp_valid && rsp_word.freq_written,
        (rsp_word.freq_word != 0) && rsp_word.duty_written && rsp_word.mode0_written)

endmodule

bind pwm_period_duty_to_registers pwm_pd_checker u_checker (.*);

`default_nettype wire
